@@ hdl/ptt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic timer table
// table entry layout, opcodes, result kinds, controller states and helpers
// ---------------------------------------------------------------------------
package ptt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int IDX_IN_W       = 4;
    localparam int NOW_W          = 48;
    localparam int DL_W           = 49;
    localparam int MS_W           = 32;
    localparam int S_DATA_W       = 120;
    localparam int M_DATA_W       = 40;

    localparam logic [DL_W-1:0] DL_MAX     = {DL_W{1'b1}};
    localparam logic [MS_W-1:0] MS_SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [MS_W-1:0] MS_NONE    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_RESET = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_FIRED  = 2'd0,
        KIND_ANSWER = 2'd1,
        KIND_NEXT   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_SCAN_END,
        ST_RESOLVE
    } state_t;

    // one table slot as held in the ram
    typedef struct packed {
        logic            armed;
        logic [DL_W-1:0] deadline;
        logic [MS_W-1:0] reload;
    } entry_t;

    // scanner control
    typedef struct packed {
        logic clr;
        logic vld;
    } scan_ctl_t;

    // scanner findings over one pass
    typedef struct packed {
        logic            found_exp;
        logic [DL_W-1:0] exp_dl;
        logic [MS_W-1:0] exp_rel;
        logic            found_any;
        logic [DL_W-1:0] any_dl;
    } scan_res_t;

    // now plus delta, clamped to the deadline width
    function automatic logic [DL_W-1:0] sat_add(input logic [NOW_W-1:0] now,
                                                input logic [MS_W-1:0] delta);
        logic [DL_W:0] sum;
        sum = {2'b00, now} + {{(DL_W + 1 - MS_W){1'b0}}, delta};
        return (sum > {1'b0, DL_MAX}) ? DL_MAX : sum[DL_W-1:0];
    endfunction

endpackage

@@ hdl/ptt_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_ram: generic single-clock ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ptt_scan.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_scan: table scanner
// tracks the earliest expired armed slot and the earliest armed deadline
// ---------------------------------------------------------------------------
module ptt_scan
    import ptt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  scan_ctl_t                                        ctl,
    input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] idx,
    input  entry_t                                           entry,
    input  logic [NOW_W-1:0]                                 now,
    output scan_res_t                                        res,
    output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] exp_idx
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic             found_exp_reg, found_exp_next;
    logic [IDX_W-1:0] exp_idx_reg, exp_idx_next;
    logic [DL_W-1:0]  exp_dl_reg, exp_dl_next;
    logic [MS_W-1:0]  exp_rel_reg, exp_rel_next;
    logic             found_any_reg, found_any_next;
    logic [DL_W-1:0]  any_dl_reg, any_dl_next;
    logic             take_exp;
    logic             take_any;

    // strict compare keeps the lower slot on equal deadlines
    assign take_exp = ctl.vld && entry.armed && (entry.deadline <= {1'b0, now}) &&
                      (!found_exp_reg || (entry.deadline < exp_dl_reg));
    assign take_any = ctl.vld && entry.armed &&
                      (!found_any_reg || (entry.deadline < any_dl_reg));

    always_comb begin
        found_exp_next = found_exp_reg;
        exp_idx_next   = exp_idx_reg;
        exp_dl_next    = exp_dl_reg;
        exp_rel_next   = exp_rel_reg;
        found_any_next = found_any_reg;
        any_dl_next    = any_dl_reg;
        if (ctl.clr) begin
            found_exp_next = 1'b0;
            found_any_next = 1'b0;
        end else begin
            if (take_exp) begin
                found_exp_next = 1'b1;
                exp_idx_next   = idx;
                exp_dl_next    = entry.deadline;
                exp_rel_next   = entry.reload;
            end
            if (take_any) begin
                found_any_next = 1'b1;
                any_dl_next    = entry.deadline;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_exp_reg <= 1'b0;
            found_any_reg <= 1'b0;
        end else begin
            found_exp_reg <= found_exp_next;
            found_any_reg <= found_any_next;
        end
        exp_idx_reg <= exp_idx_next;
        exp_dl_reg  <= exp_dl_next;
        exp_rel_reg <= exp_rel_next;
        any_dl_reg  <= any_dl_next;
    end

    assign res.found_exp = found_exp_reg;
    assign res.exp_dl    = exp_dl_reg;
    assign res.exp_rel   = exp_rel_reg;
    assign res.found_any = found_any_reg;
    assign res.any_dl    = any_dl_reg;
    assign exp_idx       = exp_idx_reg;

endmodule

@@ hdl/periodic_timer_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_timer_table: table of one-shot and periodic millisecond timers
// start, stop and reset of single slots and a tick that fires due timers
// ---------------------------------------------------------------------------
// The block keeps NUM_TIMERS timer slots (armed mark, 49-bit deadline,
// 32-bit reload interval) in one ram with a registered read, and handles
// one input word at a time. A start gives no result word. A stop or reset
// reads its slot, then writes it back and answers with one word. A tick
// sweeps the whole table, one slot per cycle through the single read port,
// to find the earliest due timer; each due timer is fired and written back
// and the sweep runs again. A stop, reset or tick waits while a result word
// is held at a stalled output. The ram needs no clearing pass: a valid flop
// per slot, cleared by reset, makes an unwritten slot read as disarmed with
// zero deadline and interval.
// ---------------------------------------------------------------------------
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input words
    input  logic                s_tvalid,
    output logic                s_tready,
    // timer_index[3:0], now_ms[51:4], delay[83:52], interval[115:84]
    input  logic [S_DATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]          s_tuser,
    // result words
    output logic                m_tvalid,
    input  logic                m_tready,
    // fired_index[3:0], was_armed[4], ms_to_next[36:5], zero fill [39:37]
    output logic [M_DATA_W-1:0] m_tdata,
    // result_kind[1:0]
    output logic [1:0]          m_tuser,
    // last_of_run
    output logic                m_tlast
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // input word fields
    logic [IDX_IN_W-1:0] in_index;
    logic [NOW_W-1:0]    in_now;
    logic [MS_W-1:0]     in_tmo;
    logic [MS_W-1:0]     in_rep;
    op_t                 in_op;
    logic                in_ok;
    logic                s_acc;

    assign in_index = s_tdata[3:0];
    assign in_now   = s_tdata[51:4];
    assign in_tmo   = s_tdata[83:52];
    assign in_rep   = s_tdata[115:84];
    assign in_op    = op_t'(s_tuser);
    assign in_ok    = (32'(in_index) < NUM_TIMERS);

    // controller state
    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [IDX_IN_W-1:0] idx_reg;
    logic                idx_ok_reg;
    logic [NOW_W-1:0]    now_reg;
    logic [MS_W-1:0]     tmo_reg;
    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [NUM_TIMERS-1:0] slot_vld_reg;

    // ram ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_q;
    entry_t           rd_entry;

    // scanner
    scan_ctl_t        scan_ctl;
    scan_res_t        scan_res;
    logic [IDX_W-1:0] scan_idx;

    // output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]          m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;
    logic                out_load;
    logic                out_free;

    // time to next deadline
    logic [DL_W-1:0] dl_diff;
    logic [MS_W-1:0] ms_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // a slot never written reads as its reset value
    assign rd_entry = slot_vld_reg[rd_idx_reg] ? ram_q : '0;

    ptt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    ptt_scan #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .idx     (rd_idx_reg),
        .entry   (rd_entry),
        .now     (now_reg),
        .res     (scan_res),
        .exp_idx (scan_idx)
    );

    // after a sweep with nothing due every armed deadline lies after now
    assign dl_diff = scan_res.any_dl - {1'b0, now_reg};

    always_comb begin
        if (!scan_res.found_any) begin
            ms_next = MS_NONE;
        end else if (scan_res.any_dl <= {1'b0, now_reg}) begin
            ms_next = '0;
        end else if (dl_diff > {{(DL_W - MS_W){1'b0}}, MS_SAT_MAX}) begin
            ms_next = MS_SAT_MAX;
        end else begin
            ms_next = dl_diff[MS_W-1:0];
        end
    end

    // next state, ram accesses and result words
    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = rd_idx_reg;
        ram_wdata     = rd_entry;
        ram_re        = 1'b0;
        ram_raddr     = scan_cnt_reg;
        scan_ctl.clr  = 1'b0;
        scan_ctl.vld  = rd_vld_reg;
        out_load      = 1'b0;
        m_tdata_next  = '0;
        m_tuser_next  = KIND_ANSWER;
        m_tlast_next  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_op)
                        OP_START: begin
                            // arm straight away, no answer
                            ram_we             = in_ok;
                            ram_waddr          = IDX_W'(in_index);
                            ram_wdata.armed    = 1'b1;
                            ram_wdata.deadline = sat_add(in_now, in_tmo);
                            ram_wdata.reload   = in_rep;
                        end
                        OP_STOP, OP_RESET: begin
                            ram_re     = in_ok;
                            ram_raddr  = IDX_W'(in_index);
                            state_next = ST_RMW;
                        end
                        OP_TICK: begin
                            scan_ctl.clr = 1'b1;
                            state_next   = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RMW: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_tuser_next = KIND_ANSWER;
                    m_tdata_next = {{(M_DATA_W - MS_W - 1 - IDX_IN_W){1'b0}}, {MS_W{1'b0}},
                                    idx_ok_reg && rd_entry.armed, idx_reg};
                    m_tlast_next = 1'b1;
                    ram_we       = idx_ok_reg;
                    if (op_reg == OP_RESET) begin
                        ram_wdata.armed    = 1'b1;
                        ram_wdata.deadline = sat_add(now_reg, tmo_reg);
                        // a periodic slot adopts the new timeout as its interval
                        ram_wdata.reload   = (rd_entry.reload != '0) ? tmo_reg : '0;
                    end else begin
                        ram_wdata.armed = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN: begin
                // one slot read per cycle
                ram_re    = 1'b1;
                ram_raddr = scan_cnt_reg;
                if (scan_cnt_reg == IDX_W'(NUM_TIMERS - 1)) begin
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN_END;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end

            ST_SCAN_END: begin
                // last slot's data lands in the scanner here
                state_next = ST_RESOLVE;
            end

            ST_RESOLVE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (scan_res.found_exp) begin
                        m_tuser_next = KIND_FIRED;
                        m_tdata_next = {{(M_DATA_W - IDX_IN_W){1'b0}},
                                        IDX_IN_W'(scan_idx)};
                        ram_we    = 1'b1;
                        ram_waddr = scan_idx;
                        if (scan_res.exp_rel != '0) begin
                            ram_wdata.armed    = 1'b1;
                            ram_wdata.deadline = sat_add(now_reg, scan_res.exp_rel);
                        end else begin
                            ram_wdata.armed    = 1'b0;
                            ram_wdata.deadline = scan_res.exp_dl;
                        end
                        ram_wdata.reload = scan_res.exp_rel;
                        // sweep again for the next due timer
                        scan_ctl.clr = 1'b1;
                        state_next   = ST_SCAN;
                    end else begin
                        m_tuser_next = KIND_NEXT;
                        m_tdata_next = {{(M_DATA_W - MS_W - 1 - IDX_IN_W){1'b0}}, ms_next,
                                        1'b0, {IDX_IN_W{1'b0}}};
                        m_tlast_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            slot_vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_vld_reg   <= (state_reg == ST_SCAN);
            if (ram_we) begin
                slot_vld_reg[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_acc) begin
            op_reg     <= in_op;
            idx_reg    <= in_index;
            idx_ok_reg <= in_ok;
            now_reg    <= in_now;
            tmo_reg    <= in_tmo;
        end
        if (ram_re) begin
            rd_idx_reg <= ram_raddr;
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // no table write while a sweep is reading the slots
    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_SCAN_END) |-> !ram_we)
        else $error("table written during a sweep");

    // a stop or reset goes through the read-modify-write step
    a_rmw_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (in_op == OP_STOP || in_op == OP_RESET)) |=> (state_reg == ST_RMW))
        else $error("stop or reset skipped its read-modify-write");

    // a timer is only fired when its deadline has come
    a_fire_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESOLVE && scan_res.found_exp) |->
        (scan_res.exp_dl <= {1'b0, now_reg}))
        else $error("timer fired before its deadline");

    // fired words never close a run nor carry a was_armed flag
    a_fired_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == KIND_FIRED) |-> (!m_tlast_reg && !m_tdata_reg[4]))
        else $error("malformed fired word");

endmodule
